// ===== rtl/core/cms_pkg.sv =====
// Types, constants and month-length function for the calendar minute stepper.
package cms_pkg;

  localparam int unsigned DataW = 32;

  localparam logic [6:0] YearMax   = 7'd99;
  localparam logic [3:0] MonthMin  = 4'd1;
  localparam logic [3:0] MonthMax  = 4'd12;
  localparam logic [3:0] MonthFeb  = 4'd2;
  localparam logic [3:0] MonthApr  = 4'd4;
  localparam logic [3:0] MonthJun  = 4'd6;
  localparam logic [3:0] MonthSep  = 4'd9;
  localparam logic [3:0] MonthNov  = 4'd11;
  localparam logic [4:0] DayMin    = 5'd1;
  localparam logic [4:0] DayMax    = 5'd31;
  localparam logic [4:0] HourMax   = 5'd23;
  localparam logic [5:0] MinuteMax = 6'd59;

  typedef enum logic {
    ModeFwd  = 1'b0,
    ModeBack = 1'b1
  } mode_e;

  typedef struct packed {
    logic [4:0] pad;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] day;
    logic [3:0] month;
    logic [6:0] year;
  } cms_in_t;

  typedef struct packed {
    logic [4:0] pad;
    logic [5:0] next_minute;
    logic [4:0] next_hour;
    logic [4:0] next_day;
    logic [3:0] next_month;
    logic [6:0] next_year;
  } cms_out_t;

  function automatic logic [4:0] month_len(logic [6:0] year, logic [3:0] month);
    logic [4:0] len;
    case (month) inside
      MonthFeb: len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
      MonthApr, MonthJun, MonthSep, MonthNov: len = 5'd30;
      default: len = DayMax;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/core/calendar_minute_stepper.sv =====
// Calendar minute stepper: moves a two-digit-year date and time one minute up or down.
//
// Takes one beat per cycle while s_axis_tready is high and returns one result beat per
// input beat, in order, once the output side is ready. The input register and the
// result register bound a single pass of clamp, carry and borrow logic; output
// back-pressure stalls both registers and deasserts s_axis_tready only when both hold
// data. Out-of-range fields are clamped into a valid date and time before the step.
module calendar_minute_stepper import cms_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [DataW-1:0] s_axis_tdata,  // year[6:0], month[10:7], day[15:11], hour[20:16],
                                          // minute[26:21], zero[31:27]
  input  logic             s_axis_tuser,  // mode: 0 forward, 1 back
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [DataW-1:0] m_axis_tdata   // next_year[6:0], next_month[10:7], next_day[15:11],
                                          // next_hour[20:16], next_minute[26:21], zero[31:27]
);

  logic     in_vld_q, in_vld_d;
  cms_in_t  in_q;
  mode_e    mode_q;
  logic     out_vld_q, out_vld_d;
  cms_out_t out_q, res;
  logic     out_free;

  logic [6:0] year_c, prev_year;
  logic [3:0] month_c, prev_month;
  logic [4:0] day_c, hour_c, len_c, prev_len;
  logic [5:0] minute_c;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || out_free;
  assign in_vld_d      = s_axis_tready ? s_axis_tvalid : in_vld_q;
  assign out_vld_d     = out_free ? in_vld_q : out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q   <= cms_in_t'(s_axis_tdata);
      mode_q <= mode_e'(s_axis_tuser);
    end
    if (out_free && in_vld_q) begin
      out_q <= res;
    end
  end

  // clamp
  always_comb begin
    year_c = (in_q.year > YearMax) ? YearMax : in_q.year;
    if (in_q.month < MonthMin) begin
      month_c = MonthMin;
    end else if (in_q.month > MonthMax) begin
      month_c = MonthMax;
    end else begin
      month_c = in_q.month;
    end
    len_c = month_len(year_c, month_c);
    if (in_q.day < DayMin) begin
      day_c = DayMin;
    end else if (in_q.day > len_c) begin
      day_c = len_c;
    end else begin
      day_c = in_q.day;
    end
    hour_c   = (in_q.hour > HourMax) ? HourMax : in_q.hour;
    minute_c = (in_q.minute > MinuteMax) ? MinuteMax : in_q.minute;
  end

  always_comb begin
    if (month_c == MonthMin) begin
      prev_month = MonthMax;
      prev_year  = (year_c == 7'd0) ? YearMax : year_c - 7'd1;
    end else begin
      prev_month = month_c - 4'd1;
      prev_year  = year_c;
    end
    prev_len = month_len(prev_year, prev_month);
  end

  // step
  always_comb begin
    res.pad         = '0;
    res.next_year   = year_c;
    res.next_month  = month_c;
    res.next_day    = day_c;
    res.next_hour   = hour_c;
    res.next_minute = minute_c;
    if (mode_q == ModeFwd) begin
      if (minute_c != MinuteMax) begin
        res.next_minute = minute_c + 6'd1;
      end else begin
        res.next_minute = 6'd0;
        if (hour_c != HourMax) begin
          res.next_hour = hour_c + 5'd1;
        end else begin
          res.next_hour = 5'd0;
          if (day_c < len_c) begin
            res.next_day = day_c + 5'd1;
          end else begin
            res.next_day = DayMin;
            if (month_c != MonthMax) begin
              res.next_month = month_c + 4'd1;
            end else begin
              res.next_month = MonthMin;
              res.next_year  = (year_c == YearMax) ? 7'd0 : year_c + 7'd1;
            end
          end
        end
      end
    end else begin
      if (minute_c != 6'd0) begin
        res.next_minute = minute_c - 6'd1;
      end else begin
        res.next_minute = MinuteMax;
        if (hour_c != 5'd0) begin
          res.next_hour = hour_c - 5'd1;
        end else begin
          res.next_hour = HourMax;
          if (day_c > DayMin) begin
            res.next_day = day_c - 5'd1;
          end else begin
            res.next_day   = prev_len;
            res.next_month = prev_month;
            res.next_year  = prev_year;
          end
        end
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = DataW'(out_q);

endmodule

// ===== rtl/core/cms_checker.sv =====
// Port-level checker for the calendar minute stepper, bound to the top level.
module cms_checker import cms_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [DataW-1:0] m_axis_tdata
);

  cms_out_t o;
  assign o = cms_out_t'(m_axis_tdata);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output back-pressure");

  a_valid_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> o.next_year <= YearMax && o.next_month >= MonthMin &&
      o.next_month <= MonthMax && o.next_day >= DayMin &&
      o.next_day <= month_len(o.next_year, o.next_month) &&
      o.next_hour <= HourMax && o.next_minute <= MinuteMax)
    else $error("result is not a valid date and time");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> o.pad == '0)
    else $error("result padding bits not zero");

endmodule

bind calendar_minute_stepper cms_checker u_cms_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
